// ===== src/shmm_pkg.sv =====
// Package for the sample history min/max unit.
// Holds the shared widths, constants, the scanner state type and the control and status structs.
// No dependencies.
package shmm_pkg;

  localparam int VAL_W  = 19;
  localparam int FILL_W = 9;

  // An entry below 1.0 mmHg (raw value below 256 in Q11.8) counts as empty.
  localparam logic [VAL_W-1:0]  EMPTY_LIMIT   = 19'd256;
  localparam logic [VAL_W-1:0]  DEADBAND_RST  = 19'd8;
  localparam logic [FILL_W-1:0] FILL_MAX      = 9'd511;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_DONE
  } shmm_state_t;

  // Control from the scanner to the cell chain.
  typedef struct packed {
    logic             shift;
    logic [VAL_W-1:0] feed;
  } shmm_ctrl_t;

  // Status from the scanner to the top level.
  typedef struct packed {
    logic              idle;
    logic              done;
    logic              accepted;
    logic [VAL_W-1:0]  lowest;
    logic [VAL_W-1:0]  highest;
    logic [FILL_W-1:0] filled;
  } shmm_stat_t;

endpackage

// ===== src/shmm_cell.sv =====
// One history entry of the cell chain.
// Depends on shmm_pkg for the entry width.
module shmm_cell
  import shmm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  logic [VAL_W-1:0] d_in,
  output logic [VAL_W-1:0] d_out
);

  logic [VAL_W-1:0] data_r;

  // Take the neighbor's entry on every shift cycle; reset empties the entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (shift) begin
      data_r <= d_in;
    end
  end

  assign d_out = data_r;

endmodule

// ===== src/shmm_scan.sv =====
// Scanner and sequencer: deadband check, min/max/count over the entries that pass the
// chain head, and the feedback value written into the tail cell. Depends on shmm_pkg.
module shmm_scan
  import shmm_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_beat,
  input  logic [VAL_W-1:0] sample,
  input  logic [VAL_W-1:0] deadband,
  input  logic             ack,
  input  logic [VAL_W-1:0] head,
  output shmm_ctrl_t       ctrl,
  output shmm_stat_t       stat
);

  localparam int IW = $clog2(WINDOW);
  localparam logic [IW-1:0] POS_LAST = IW'(WINDOW - 1);

  shmm_state_t       state_r, state_nxt;
  logic [IW-1:0]     pos_r;
  logic [VAL_W-1:0]  sample_r;
  logic [VAL_W-1:0]  last_r;
  logic              acc_r;
  logic              found_r;
  logic [VAL_W-1:0]  lo_r, lo_nxt;
  logic [VAL_W-1:0]  hi_r, hi_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]  held_lo_r;
  logic [VAL_W-1:0]  held_hi_r;
  logic [FILL_W-1:0] held_cnt_r;

  logic [VAL_W-1:0]  diff;
  logic              pass;
  logic              first;
  logic              pos_end;
  logic              empty;
  logic              found_cur;
  logic              found_nxt;
  logic              upd;
  logic              replace;
  logic [FILL_W-1:0] cnt_base;

  // Deadband check against the last accepted sample.
  always_comb begin
    diff = (sample > last_r) ? (sample - last_r) : (last_r - sample);
    pass = diff > deadband;
  end

  // Scan step for the entry now at the chain head.
  always_comb begin
    first     = (pos_r == '0);
    pos_end   = (pos_r == POS_LAST);
    empty     = head < EMPTY_LIMIT;
    found_cur = first ? 1'b0 : found_r;
    found_nxt = found_cur | empty;
    upd       = !found_cur && !empty;
    replace   = !found_cur && empty;
    cnt_base  = first ? '0 : cnt_r;
    // Minimum and maximum both start from entry 0, empty or not.
    lo_nxt  = first ? head : ((upd && head < lo_r) ? head : lo_r);
    hi_nxt  = first ? head : ((upd && head > hi_r) ? head : hi_r);
    cnt_nxt = (upd && cnt_base != FILL_MAX) ? cnt_base + 1'b1 : cnt_base;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) state_nxt = pass ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        if (pos_end) state_nxt = found_nxt ? ST_DONE : ST_APPEND;
      end
      ST_APPEND: state_nxt = ST_DONE;
      ST_DONE: begin
        if (ack) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: the chain rotates during a scan; the first empty entry is replaced
  // by the sample. A full store gets one more shift that drops entry 0.
  always_comb begin
    ctrl.shift = 1'b0;
    ctrl.feed  = head;
    unique case (state_r)
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        ctrl.feed  = replace ? sample_r : head;
      end
      ST_APPEND: begin
        ctrl.shift = 1'b1;
        ctrl.feed  = sample_r;
      end
      ST_IDLE, ST_DONE: begin
        ctrl.shift = 1'b0;
        ctrl.feed  = head;
      end
      default: begin
        ctrl.shift = 1'b0;
        ctrl.feed  = head;
      end
    endcase
    stat.idle     = (state_r == ST_IDLE);
    stat.done     = (state_r == ST_DONE);
    stat.accepted = acc_r;
    stat.lowest   = held_lo_r;
    stat.highest  = held_hi_r;
    stat.filled   = held_cnt_r;
  end

  // State and held values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      last_r     <= '0;
      acc_r      <= 1'b0;
      held_lo_r  <= '0;
      held_hi_r  <= '0;
      held_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_beat) begin
        acc_r <= pass;
        if (pass) last_r <= sample;
      end
      if (state_r == ST_SCAN && pos_end) begin
        held_lo_r  <= lo_nxt;
        held_hi_r  <= hi_nxt;
        held_cnt_r <= cnt_nxt;
      end
    end
  end

  // Scan datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_beat) begin
      sample_r <= sample;
      pos_r    <= '0;
    end else if (state_r == ST_SCAN) begin
      pos_r   <= pos_r + 1'b1;
      found_r <= found_nxt;
      lo_r    <= lo_nxt;
      hi_r    <= hi_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== src/sample_history_min_max_unit.sv =====
// Top level of the sample history min/max unit: cell chain, scanner, deadband
// register and result register. Depends on shmm_pkg, shmm_cell and shmm_scan.
//
//  channel | direction | payload
//  in_     | slave     | tdata[18:0] sample (Q11.8 mmHg)
//  out_    | master    | tuser accepted; tdata lowest, highest, filled
//  cfg_    | slave     | data[18:0] deadband
//
// A rejected sample goes from IDLE straight to DONE; an accepted one is scanned in SCAN
// while the entries rotate one per cycle through the cell chain past the scanner at its
// head, then also passes APPEND when the store is full, before DONE and the result register.
// Synchronous active-low reset empties every cell and clears the held values.
// The result register frees the scanner; a stalled result holds the next item in DONE.
module sample_history_min_max_unit
  import shmm_pkg::*;
#(
  parameter int WINDOW = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [18:0] sample, [23:19] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [18:0] lowest, [37:19] highest, [46:38] filled, [47] zero
  output logic        out_tuser,  // [0] accepted
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [18:0] cfg_data    // [18:0] deadband
);

  logic [VAL_W-1:0] cell_q [WINDOW];
  logic [VAL_W-1:0] deadband_r;
  shmm_ctrl_t       ctrl;
  shmm_stat_t       stat;
  logic             in_beat;
  logic             ack;
  logic             out_valid_r;
  logic [47:0]      out_data_r;
  logic             out_user_r;

  // Deadband register; writes are taken whenever reset is released.
  assign cfg_ready = rst_n;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
    end else if (cfg_valid) begin
      deadband_r <= cfg_data;
    end
  end

  // Cell chain: each cell hands its entry toward entry 0; the tail takes the feedback.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_tail
      shmm_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(ctrl.shift),
        .d_in (ctrl.feed),
        .d_out(cell_q[i])
      );
    end else begin : g_body
      shmm_cell u_cell (
        .clk  (clk),
        .rst_n(rst_n),
        .shift(ctrl.shift),
        .d_in (cell_q[i+1]),
        .d_out(cell_q[i])
      );
    end
  end

  // The input opens only out of reset while the scanner is idle.
  assign in_tready = stat.idle && rst_n;
  assign in_beat   = in_tvalid && in_tready;

  shmm_scan #(
    .WINDOW(WINDOW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_beat),
    .sample  (in_tdata[VAL_W-1:0]),
    .deadband(deadband_r),
    .ack     (ack),
    .head    (cell_q[0]),
    .ctrl    (ctrl),
    .stat    (stat)
  );

  // Result register.
  assign ack = stat.done && (!out_valid_r || out_tready);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ack) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_data_r <= {1'b0, stat.filled, stat.highest, stat.lowest};
      out_user_r <= stat.accepted;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // An input beat is followed by a cycle with the input closed.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // A non-empty held prefix has its minimum no greater than its maximum.
  a_lo_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46:38] != '0 |-> out_tdata[18:0] <= out_tdata[37:19])
    else $error("held minimum above held maximum");

  // The chain only moves while the scanner is busy.
  a_shift_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.shift |-> !stat.idle && !stat.done)
    else $error("cell chain shifted outside a scan");

endmodule

// ===== sim/tb_sample_history_min_max_unit.sv =====
// Self-checking testbench for the sample history min/max unit: directed rows, then random
// pressure samples across several deadband settings, with random source gaps and sink stalls.
// Depends on shmm_pkg and sample_history_min_max_unit.
module tb_sample_history_min_max_unit;
  import shmm_pkg::*;

  localparam int WINDOW = 256;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 140;
  localparam int HOLD_CYCLES = 2000;
  localparam int MAX_SAMPLE = 524287;
  localparam logic [VAL_W-1:0] SAMPLE_MAX = '1;

  // One result beat as the block reports it.
  typedef struct packed {
    logic              accepted;
    logic [VAL_W-1:0]  lowest;
    logic [VAL_W-1:0]  highest;
    logic [FILL_W-1:0] filled;
  } reading_t;

  typedef enum logic {
    ROW_SAMPLE,
    ROW_BAND
  } row_kind_t;

  // A directed row: a sample or a deadband write, with an optional hand-written result.
  typedef struct {
    row_kind_t        kind;
    logic [VAL_W-1:0] value;
    bit               typed;
    reading_t         want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // [18:0] sample, [23:19] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // [18:0] lowest, [37:19] highest, [46:38] filled, [47] zero
  logic        out_tuser;        // [0] accepted
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [18:0] cfg_data = '0;    // [18:0] deadband

  // Predicted state of the pressure history.
  logic [VAL_W-1:0]  hist_mem [WINDOW];
  logic [VAL_W-1:0]  prev_kept;
  logic [VAL_W-1:0]  kept_low;
  logic [VAL_W-1:0]  kept_high;
  logic [FILL_W-1:0] kept_count;
  logic [VAL_W-1:0]  band;

  reading_t  pending_readings [$];
  stim_row_t directed_rows [$];

  int fail_count = 0;
  int samples_sent = 0;
  int samples_stored = 0;
  int readings_checked = 0;
  int band_writes = 0;
  int max_fill = 0;
  int burst_left = 0;
  bit sender_steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int rx_cycle = 0;

  sample_history_min_max_unit #(
    .WINDOW(WINDOW)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit, well beyond the slowest legal run.
  initial begin
    #8000000;
    $display("sample_history_min_max_unit verification failed");
    $finish;
  end

  // Predicts the result of one sample and updates the history as the block should.
  task automatic predict_reading(input logic [VAL_W-1:0] s, output reading_t r);
    logic [VAL_W-1:0] diff;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    int cnt;
    int slot;
    logic acc;
    diff = (s > prev_kept) ? s - prev_kept : prev_kept - s;
    acc = 1'b0;
    if (diff > band) begin
      lo = hist_mem[0];
      hi = hist_mem[0];
      cnt = 0;
      slot = WINDOW;
      // Scan the non-empty prefix; the first entry below 1.0 ends it.
      for (int i = 0; i < WINDOW; i++) begin
        if (slot == WINDOW) begin
          if (hist_mem[i] < EMPTY_LIMIT) begin
            slot = i;
          end else begin
            if (hist_mem[i] < lo) lo = hist_mem[i];
            if (hist_mem[i] > hi) hi = hist_mem[i];
            cnt++;
          end
        end
      end
      // A full store drops its oldest entry.
      if (slot == WINDOW) begin
        for (int i = 0; i < WINDOW - 1; i++) hist_mem[i] = hist_mem[i + 1];
        slot = WINDOW - 1;
      end
      hist_mem[slot] = s;
      kept_low = lo;
      kept_high = hi;
      kept_count = (cnt > int'(FILL_MAX)) ? FILL_MAX : cnt[FILL_W-1:0];
      prev_kept = s;
      acc = 1'b1;
      samples_stored++;
      if (cnt > max_fill) max_fill = cnt;
    end
    r = {acc, kept_low, kept_high, kept_count};
  endtask

  // Offers one sample in bursts with random gaps and records its expected result.
  task automatic offer_sample(input logic [VAL_W-1:0] s, input bit typed, input reading_t want);
    reading_t r;
    int gap;
    if (burst_left == 0) begin
      gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, s};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    predict_reading(s, r);
    pending_readings.push_back(typed ? want : r);
    samples_sent++;
  endtask

  // Writes the deadband once every pending result has come back.
  task automatic write_band(input logic [VAL_W-1:0] v);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_readings.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    band = v;
    band_writes++;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [VAL_W-1:0] value, input bit typed,
                         input logic acc, input logic [VAL_W-1:0] lo,
                         input logic [VAL_W-1:0] hi, input logic [FILL_W-1:0] fill);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.typed = typed;
    row.want = {acc, lo, hi, fill};
    directed_rows.push_back(row);
  endtask

  // Random sample: mostly fresh or near the last stored one, some below 1.0 and edge values.
  function automatic logic [VAL_W-1:0] draw_sample();
    int pick;
    int span;
    int delta;
    int v;
    pick = $urandom_range(0, 99);
    span = (band > 4000) ? 4000 : int'(band) + 3;
    delta = $urandom_range(0, span);
    v = int'(prev_kept);
    if (pick < 35) begin
      v = $urandom_range(0, MAX_SAMPLE);
    end else if (pick < 75) begin
      v = $urandom_range(0, 1) ? v + delta : v - delta;
    end else if (pick < 85) begin
      v = $urandom_range(0, 255);
    end else if (pick >= 92) begin
      case ($urandom_range(0, 3))
        0: v = 0;
        1: v = 255;
        2: v = 256;
        default: v = MAX_SAMPLE;
      endcase
    end
    if (v < 0) v = 0;
    if (v > MAX_SAMPLE) v = MAX_SAMPLE;
    return v[VAL_W-1:0];
  endfunction

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Result side: check each beat, then pick the next ready level.
  always @(posedge clk) begin
    reading_t got;
    reading_t want;
    if (out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata[18:0], out_tdata[37:19], out_tdata[46:38]};
      if (pending_readings.size() == 0) begin
        $error("result beat with no sample pending");
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(got.accepted));
        check_field("lowest", 32'(want.lowest), 32'(got.lowest));
        check_field("highest", 32'(want.highest), 32'(got.highest));
        check_field("filled", 32'(want.filled), 32'(got.filled));
        readings_checked++;
      end
    end
    rx_cycle++;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
      if (hold_left == 0) hold_done = 1'b1;
    end else if (hold_req && !hold_done) begin
      out_tready <= 1'b0;
      hold_left = HOLD_CYCLES;
    end else begin
      case ((rx_cycle / 5000) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ((rx_cycle % 17) < 11);
      endcase
    end
  end

  initial begin
    int unsigned phase_band [PHASES];
    for (int i = 0; i < WINDOW; i++) hist_mem[i] = '0;
    prev_kept = '0;
    kept_low = '0;
    kept_high = '0;
    kept_count = '0;
    band = DEADBAND_RST;

    // Directed rows. Hand-written results follow from the reset state and the deadband.
    add_row(ROW_SAMPLE, 19'd0, 1, 1'b0, 19'd0, 19'd0, 9'd0);
    add_row(ROW_SAMPLE, 19'd8, 1, 1'b0, 19'd0, 19'd0, 9'd0);
    add_row(ROW_SAMPLE, 19'd9, 1, 1'b1, 19'd0, 19'd0, 9'd0);
    add_row(ROW_SAMPLE, 19'd100, 1, 1'b1, 19'd9, 19'd9, 9'd0);
    add_row(ROW_SAMPLE, SAMPLE_MAX, 1, 1'b1, 19'd100, 19'd100, 9'd0);
    add_row(ROW_SAMPLE, SAMPLE_MAX, 1, 1'b0, 19'd100, 19'd100, 9'd0);
    add_row(ROW_SAMPLE, 19'd256, 1, 1'b1, SAMPLE_MAX, SAMPLE_MAX, 9'd1);
    add_row(ROW_SAMPLE, 19'd255, 1, 1'b0, SAMPLE_MAX, SAMPLE_MAX, 9'd1);
    add_row(ROW_BAND, 19'd0, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'd255, 1, 1'b1, 19'd256, SAMPLE_MAX, 9'd2);
    add_row(ROW_SAMPLE, 19'd255, 1, 1'b0, 19'd256, SAMPLE_MAX, 9'd2);
    add_row(ROW_SAMPLE, 19'h55555, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'h2AAAA, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'h2AAAA, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'h2AAA9, 0, 1'b0, '0, '0, '0);
    add_row(ROW_BAND, SAMPLE_MAX, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'd0, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, SAMPLE_MAX, 0, 1'b0, '0, '0, '0);
    add_row(ROW_BAND, 19'd1, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'h2AAAB, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'h2AAAC, 0, 1'b0, '0, '0, '0);
    add_row(ROW_SAMPLE, 19'd0, 0, 1'b0, '0, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_BAND) begin
        write_band(directed_rows[i].value);
      end else begin
        offer_sample(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // Random phases, each with its own deadband; the long sink hold-off lands in the third.
    phase_band[0] = 0;
    phase_band[1] = $urandom_range(1, 16);
    phase_band[2] = $urandom_range(16, 2048);
    phase_band[3] = $urandom_range(0, MAX_SAMPLE);
    phase_band[4] = $urandom_range(0, 64);
    for (int p = 0; p < PHASES; p++) begin
      write_band(phase_band[p][VAL_W-1:0]);
      sender_steady = (p == 1);
      if (p == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer_sample(draw_sample(), 0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_readings.size() != 0) @(posedge clk);
    repeat (WINDOW + 8) @(posedge clk);

    $display("Checked %0d results for %0d samples, %0d stored, deadband set %0d times.",
             readings_checked, samples_sent, samples_stored, band_writes);
    $display("History reached %0d of %0d entries; sink held off %0d cycles once.",
             max_fill, WINDOW, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("sample_history_min_max_unit verification clean");
    end else begin
      $display("sample_history_min_max_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/shmm_pkg.sv
src/shmm_cell.sv
src/shmm_scan.sv
src/sample_history_min_max_unit.sv
sim/tb_sample_history_min_max_unit.sv
